// ----- sv/hlsf_pkg.sv -----
// Package for the hashed LRU slot finder: field widths, hash constant,
// the request, response and table entry structs and the outcome codes.
// No dependencies.
package hlsf_pkg;

  localparam int unsigned CodepointW = 21;
  localparam int unsigned PixelSizeW = 8;
  localparam int unsigned SlotW      = 9;
  localparam int unsigned OutcomeW   = 2;
  localparam int unsigned KeyW       = 32;
  localparam int unsigned StampW     = 64;

  localparam logic [KeyW-1:0] HashMult = 32'h9E37_79B1;

  typedef enum logic [OutcomeW-1:0] {
    OUTCOME_HIT     = 2'd0,
    OUTCOME_TAKEN   = 2'd1,
    OUTCOME_EVICTED = 2'd2
  } outcome_e;

  typedef struct packed {
    logic [CodepointW-1:0] codepoint;
    logic [PixelSizeW-1:0] pixel_size;
  } req_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    outcome_e         outcome;
  } rsp_t;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [StampW-1:0] stamp;
  } entry_t;

endpackage

// ----- sv/hlsf_hash.sv -----
// Home slot unit: multiplicative hash of the key, then the remainder modulo the table
// size by reciprocal multiplication with one correction step.
// Depends on hlsf_pkg.
module hlsf_hash #(
  parameter int unsigned TableEntries = 512
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [hlsf_pkg::KeyW-1:0]           key_i,
  output logic                                done_o,
  output logic [$clog2(TableEntries)-1:0]     home_o
);
  import hlsf_pkg::*;

  localparam int unsigned AddrW = $clog2(TableEntries);
  localparam logic [KeyW-1:0] Recip   = KeyW'((64'd1 << KeyW) / 64'(TableEntries));
  localparam logic [KeyW-1:0] Entries = KeyW'(TableEntries);

  logic [2:0]         stage_q, stage_d;
  logic               done_q, done_d;
  logic [KeyW-1:0]    hash_q, hash_d;
  logic [KeyW-1:0]    quot_q, quot_d;
  logic [AddrW:0]     rem_q, rem_d;
  logic [AddrW-1:0]   home_q, home_d;
  logic [2*KeyW-1:0]  recip_prod;
  logic [KeyW-1:0]    back_prod;
  logic [KeyW-1:0]    diff;
  logic               fits;

  assign recip_prod = {{KeyW{1'b0}}, hash_q} * {{KeyW{1'b0}}, Recip};
  assign back_prod  = quot_q * Entries;
  assign diff       = hash_q - back_prod;
  assign fits       = rem_q >= (AddrW+1)'(TableEntries);

  always_comb begin
    stage_d = {stage_q[1:0], start_i};
    done_d  = stage_q[2];
    hash_d  = hash_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    home_d  = home_q;
    if (start_i) begin
      hash_d = KeyW'(key_i * HashMult);
    end
    if (stage_q[0]) begin
      quot_d = recip_prod[2*KeyW-1:KeyW];
    end
    if (stage_q[1]) begin
      rem_d = diff[AddrW:0];
    end
    if (stage_q[2]) begin
      home_d = fits ? AddrW'(rem_q - (AddrW+1)'(TableEntries)) : rem_q[AddrW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
      done_q  <= 1'b0;
    end else begin
      stage_q <= stage_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    home_q <= home_d;
  end

  assign done_o = done_q;
  assign home_o = home_q;

endmodule

// ----- sv/hlsf_mem.sv -----
// Table memory holding key and stamp of every entry: one write port and
// one read port with registered read data. Depends on hlsf_pkg.
module hlsf_mem #(
  parameter int unsigned Depth = 512
) (
  input  logic                         clk_i,
  input  logic                         re_i,
  input  logic [$clog2(Depth)-1:0]     raddr_i,
  output hlsf_pkg::entry_t             rdata_o,
  input  logic                         we_i,
  input  logic [$clog2(Depth)-1:0]     waddr_i,
  input  hlsf_pkg::entry_t             wdata_i
);
  import hlsf_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/hashed_lru_slot_finder.sv -----
// Top level of the hashed LRU slot finder: probe sequencer, use clock and
// output register. Depends on hlsf_pkg, hlsf_hash and hlsf_mem.
//
// After reset the block clears every entry of the table memory before it
// takes its first word. A request then passes in turn through the hash
// multiply and the reciprocal-multiplication remainder that maps it onto the
// table, one memory read per probe (at most PROBE_LIMIT) on the single read
// port, a check of the last read data and the write-back of the chosen entry,
// and then returns to idle; only then is the next word taken. The write-back
// waits while the output register still holds a response that has not been
// taken, and the response enters the output register with the write-back. A
// new request is taken while the previous response still waits in the output
// register.
module hashed_lru_slot_finder #(
  parameter int unsigned TABLE_ENTRIES = 512,
  parameter int unsigned PROBE_LIMIT   = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hlsf_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hlsf_pkg::rsp_t out_rsp_o
);
  import hlsf_pkg::*;

  localparam int unsigned AddrW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntW  = $clog2(PROBE_LIMIT + 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_HASH  = 5'b00100,
    ST_PROBE = 5'b01000,
    ST_WRITE = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [AddrW-1:0]   clr_addr_q, clr_addr_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [StampW-1:0]  use_clock_q, use_clock_d;
  logic [AddrW-1:0]   issue_slot_q, issue_slot_d;
  logic [CntW-1:0]    issue_cnt_q, issue_cnt_d;
  logic               chk_valid_q, chk_valid_d;
  logic               chk_first_q, chk_first_d;
  logic [AddrW-1:0]   chk_slot_q, chk_slot_d;
  logic [AddrW-1:0]   victim_q, victim_d;
  logic [StampW-1:0]  victim_age_q, victim_age_d;
  logic [AddrW-1:0]   chosen_q, chosen_d;
  outcome_e           outcome_q, outcome_d;
  rsp_t               rsp_q, rsp_d;
  logic               out_valid_q, out_valid_d;

  logic               in_accept;
  logic               hash_done;
  logic [AddrW-1:0]   hash_home;
  logic               mem_re, mem_we;
  logic [AddrW-1:0]   mem_waddr;
  entry_t             mem_rdata, mem_wdata;
  logic               write_go;
  logic [AddrW-1:0]   vic_slot_n;
  logic [StampW-1:0]  vic_age_n;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign write_go   = (state_q == ST_WRITE) && (!out_valid_q || out_ready_i);

  hlsf_hash #(
    .TableEntries(TABLE_ENTRIES)
  ) u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(in_accept),
    .key_i  (KeyW'({in_req_i.codepoint, in_req_i.pixel_size})),
    .done_o (hash_done),
    .home_o (hash_home)
  );

  hlsf_mem #(
    .Depth(TABLE_ENTRIES)
  ) u_mem (
    .clk_i  (clk_i),
    .re_i   (mem_re),
    .raddr_i(issue_slot_q),
    .rdata_o(mem_rdata),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata)
  );

  always_comb begin
    vic_slot_n   = victim_q;
    vic_age_n    = victim_age_q;
    if (chk_first_q || (mem_rdata.stamp < victim_age_q)) begin
      vic_slot_n = chk_slot_q;
      vic_age_n  = mem_rdata.stamp;
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_addr_d   = clr_addr_q;
    key_d        = key_q;
    use_clock_d  = use_clock_q;
    issue_slot_d = issue_slot_q;
    issue_cnt_d  = issue_cnt_q;
    chk_valid_d  = 1'b0;
    chk_first_d  = chk_first_q;
    chk_slot_d   = chk_slot_q;
    victim_d     = victim_q;
    victim_age_d = victim_age_q;
    chosen_d     = chosen_q;
    outcome_d    = outcome_q;
    rsp_d        = rsp_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = chosen_q;
    mem_wdata.key   = key_q;
    mem_wdata.stamp = use_clock_q + 1'b1;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_q;
        mem_wdata = '0;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == AddrW'(TABLE_ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          key_d   = KeyW'({in_req_i.codepoint, in_req_i.pixel_size});
          state_d = ST_HASH;
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          issue_slot_d = hash_home;
          issue_cnt_d  = '0;
          state_d      = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (issue_cnt_q < CntW'(PROBE_LIMIT)) begin
          mem_re       = 1'b1;
          chk_valid_d  = 1'b1;
          chk_first_d  = (issue_cnt_q == '0);
          chk_slot_d   = issue_slot_q;
          issue_cnt_d  = issue_cnt_q + 1'b1;
          issue_slot_d = (issue_slot_q == AddrW'(TABLE_ENTRIES - 1)) ? '0
                                                                     : issue_slot_q + 1'b1;
        end
        if (chk_valid_q) begin
          if (mem_rdata.key == key_q) begin
            chosen_d  = chk_slot_q;
            outcome_d = OUTCOME_HIT;
            state_d   = ST_WRITE;
          end else if (mem_rdata.key == '0) begin
            chosen_d  = chk_slot_q;
            outcome_d = OUTCOME_TAKEN;
            state_d   = ST_WRITE;
          end else begin
            victim_d     = vic_slot_n;
            victim_age_d = vic_age_n;
            if (issue_cnt_q == CntW'(PROBE_LIMIT)) begin
              chosen_d  = vic_slot_n;
              outcome_d = OUTCOME_EVICTED;
              state_d   = ST_WRITE;
            end
          end
        end
      end
      ST_WRITE: begin
        if (write_go) begin
          mem_we        = 1'b1;
          use_clock_d   = use_clock_q + 1'b1;
          rsp_d.slot    = SlotW'(chosen_q);
          rsp_d.outcome = outcome_q;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      use_clock_q <= '0;
      issue_cnt_q <= '0;
      chk_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      use_clock_q <= use_clock_d;
      issue_cnt_q <= issue_cnt_d;
      chk_valid_q <= chk_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    issue_slot_q <= issue_slot_d;
    chk_first_q  <= chk_first_d;
    chk_slot_q   <= chk_slot_d;
    victim_q     <= victim_d;
    victim_age_q <= victim_age_d;
    chosen_q     <= chosen_d;
    outcome_q    <= outcome_d;
    rsp_q        <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // Reads and the write-back never share a cycle, so no forwarding is needed.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_re && mem_we))
    else $error("table read and write in the same cycle");

  a_one_word_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ready_o)
    else $error("second word taken while one is in progress");

  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE) |-> (issue_cnt_q <= CntW'(PROBE_LIMIT)))
    else $error("probe count beyond limit");

  a_clock_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !write_go |=> $stable(use_clock_q))
    else $error("use clock moved without a write-back");

endmodule

// ----- tb/hashed_lru_slot_finder_tb.sv -----
// Self-checking testbench for hashed_lru_slot_finder: a scoreboard class predicts the slot
// and outcome of every accepted request word and checks each response word against it.
// Depends on hlsf_pkg and the hashed_lru_slot_finder RTL.
module hashed_lru_slot_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hlsf_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 512;
  localparam int unsigned PROBE_LIMIT   = 64;
  localparam int unsigned CycleLimit    = 1_000_000;
  localparam int unsigned ClusterBase   = TABLE_ENTRIES - 12;
  localparam int unsigned PhaseWords    = 427;
  localparam int unsigned MaxCodepoint  = 1114111;

  class slot_scoreboard;
    int unsigned entries;
    int unsigned probes;
    logic [KeyW-1:0] key_tab[];
    logic [StampW-1:0] stamp_tab[];
    logic [StampW-1:0] use_clock;
    rsp_t expected_q[$];
    int unsigned mismatches;
    int unsigned requests;
    int unsigned hits;
    int unsigned fills;
    int unsigned evictions;
    int unsigned zero_keys;

    function new(int unsigned n_entries, int unsigned n_probes);
      entries = n_entries;
      probes = n_probes;
      key_tab = new[n_entries];
      stamp_tab = new[n_entries];
      foreach (key_tab[i]) begin
        key_tab[i] = '0;
        stamp_tab[i] = '0;
      end
      use_clock = '0;
      mismatches = 0;
      requests = 0;
      hits = 0;
      fills = 0;
      evictions = 0;
      zero_keys = 0;
    endfunction

    function int unsigned home_of(req_t w);
      logic [KeyW-1:0] key;
      logic [KeyW-1:0] product;
      key = KeyW'(w);
      product = key * HashMult;
      return product % entries;
    endfunction

    function void note_word(req_t w);
      logic [KeyW-1:0] key;
      logic [StampW-1:0] oldest;
      int unsigned home;
      int unsigned s;
      int unsigned victim;
      int unsigned pick;
      int unsigned p;
      outcome_e verdict;
      rsp_t r;
      key = KeyW'(w);
      home = home_of(w);
      victim = home;
      pick = home;
      oldest = stamp_tab[home];
      verdict = OUTCOME_EVICTED;
      for (p = 0; p < probes; p++) begin
        s = (home + p) % entries;
        if (key_tab[s] == key) begin
          pick = s;
          verdict = OUTCOME_HIT;
          break;
        end
        if (key_tab[s] == '0) begin
          pick = s;
          verdict = OUTCOME_TAKEN;
          break;
        end
        if (stamp_tab[s] < oldest) begin
          oldest = stamp_tab[s];
          victim = s;
        end
      end
      if (verdict == OUTCOME_EVICTED) begin
        pick = victim;
      end
      use_clock = use_clock + 1'b1;
      stamp_tab[pick] = use_clock;
      if (verdict != OUTCOME_HIT) begin
        key_tab[pick] = key;
      end
      requests++;
      if (key == '0) begin
        zero_keys++;
      end
      case (verdict)
        OUTCOME_HIT: hits++;
        OUTCOME_TAKEN: fills++;
        default: evictions++;
      endcase
      r.slot = pick[SlotW-1:0];
      r.outcome = verdict;
      expected_q.push_back(r);
    endfunction

    function void check_word(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected response word: slot %0d outcome %0d", got.slot, got.outcome);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.slot !== want.slot || got.outcome !== want.outcome) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Response mismatch: expected slot %0d outcome %0d, got slot %0d outcome %0d",
                   want.slot, want.outcome, got.slot, got.outcome);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_rsp_o;

  int unsigned send_idle_pct = 26;
  int unsigned recv_stall_pct = 76;
  int unsigned cycle_count = 0;

  slot_scoreboard sb = new(TABLE_ENTRIES, PROBE_LIMIT);

  hashed_lru_slot_finder #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .PROBE_LIMIT  (PROBE_LIMIT)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_word(out_rsp_o);
      end
      out_ready_i <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  task automatic send_word(input req_t w);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin
    req_t directed_q[$];
    req_t recent_q[$];
    req_t w;
    int unsigned roll;
    int unsigned tries;
    int unsigned send_pct[3];
    int unsigned recv_pct[3];
    send_pct = '{26, 76, 0};
    recv_pct = '{76, 26, 0};
    directed_q = '{
      {21'd0, 8'd0}, {21'd1114111, 8'd255}, {21'd1114111, 8'd0}, {21'd0, 8'd255},
      {21'd0, 8'd1}, {21'h0FFFFF, 8'h80}, {21'h0AAAAA, 8'hAA}, {21'h055555, 8'h55},
      {21'h100000, 8'h01}, {21'd65, 8'd16}, {21'd65, 8'd32}, {21'd1114111, 8'd255},
      {21'd0, 8'd1}, {21'h0AAAAA, 8'hAA}, {21'd0, 8'd0}, {21'd65, 8'd16},
      {21'h10FFFF, 8'h7F}, {21'h0FFFFF, 8'h80}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (directed_q[i]) begin
      send_word(directed_q[i]);
      recent_q.push_back(directed_q[i]);
    end
    drain_results();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = send_pct[phase];
      recv_stall_pct = recv_pct[phase];
      for (int n = 0; n < PhaseWords; n++) begin
        roll = $urandom_range(99, 0);
        if (roll < 35) begin
          w = recent_q[$urandom_range(recent_q.size() - 1, 0)];
        end else if (roll < 38) begin
          w = '0;
        end else begin
          tries = 0;
          do begin
            w.codepoint = CodepointW'($urandom_range(MaxCodepoint, 0));
            w.pixel_size = PixelSizeW'($urandom_range(255, 0));
            tries++;
          end while (roll < 70 && sb.home_of(w) < ClusterBase && tries < 4096);
          recent_q.push_back(w);
          if (recent_q.size() > 96) begin
            void'(recent_q.pop_front());
          end
        end
        send_word(w);
      end
      drain_results();
    end
    repeat (PROBE_LIMIT + 64) @(posedge clk_i);
    $display("Sent %0d request words over three pacing phases: %0d hits, %0d empty-slot fills,",
             sb.requests, sb.hits, sb.fills);
    $display("%0d evictions, %0d requests with key zero, %0d mismatches.",
             sb.evictions, sb.zero_keys, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/hlsf_pkg.sv
sv/hlsf_hash.sv
sv/hlsf_mem.sv
sv/hashed_lru_slot_finder.sv
tb/hashed_lru_slot_finder_tb.sv
